// ===== hdl/teq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] LATE_HALF = 32'h8000_0000;
    localparam logic [31:0] LATE_WINDOW = 32'h1000_0000;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] REG_SPECIAL_TYPE = 2'd0;
    localparam logic [1:0] REG_COMPARE_TYPE = 2'd1;

    typedef enum logic [2:0] {
        OP_ADD_DELAY = 3'd0,
        OP_ADD_AT    = 3'd1,
        OP_POP       = 3'd2,
        OP_DELETE    = 3'd3,
        OP_FIND      = 3'd4,
        OP_REBASE    = 3'd5,
        OP_CLEAR     = 3'd6
    } teq_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT
    } teq_cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RB_DEL_SPECIAL,
        ST_RB_SHIFT,
        ST_RB_ADD_COMPARE,
        ST_RB_ADD_SPECIAL,
        ST_OUT
    } teq_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  event_type;
        logic [31:0] value;
        logic [31:0] now_count;
        logic [31:0] compare_value;
        logic        to_front;
    } teq_req_t;

    typedef struct packed {
        logic [31:0] next_due;
        logic [31:0] found_count;
        logic [3:0]  head_type;
        logic        is_empty;
        logic        was_present;
        logic [1:0]  status;
    } teq_rsp_t;

    typedef struct packed {
        teq_cell_op_t op;
        logic         from_head;
        logic [3:0]   key_type;
        logic [31:0]  new_due;
        logic [31:0]  new_dist;
        logic         front;
        logic         key_special;
        logic [3:0]   special_type;
        logic         special_done;
        logic [31:0]  now_count;
        logic [31:0]  offset;
    } teq_cmd_t;

    typedef struct packed {
        logic        any_match;
        logic [31:0] found_due;
        logic        ins_head;
        logic [3:0]  head_type;
        logic [31:0] head_due;
        logic [31:0] second_due;
    } teq_stat_t;

endpackage

// ===== hdl/teq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_cell
// One queue slot: holds an event, ranks it against a new one and shifts.
// ----------------------------------------------------------------------------
module teq_cell
    import teq_pkg::*;
(
    input  logic        aclk,
    input  teq_cmd_t    cmd,
    input  logic        valid,
    input  logic [3:0]  prev_type,
    input  logic [31:0] prev_due,
    input  logic [3:0]  next_type,
    input  logic [31:0] next_due,
    input  logic        found_in,
    input  logic [31:0] fdue_in,
    input  logic        reach_in,
    input  logic        point_in,
    output logic [3:0]  cell_type,
    output logic [31:0] cell_due,
    output logic        found_out,
    output logic [31:0] fdue_out,
    output logic        reach_out,
    output logic        point_out
);

    logic [3:0]  type_reg, type_next;
    logic [31:0] due_reg, due_next;
    logic [31:0] lead, late;
    logic        hit, ranks, reach, settle, here;

    assign lead = due_reg - cmd.now_count;
    assign late = cmd.now_count - due_reg;
    assign hit = valid && (type_reg == cmd.key_type);

    always_comb begin
        if (cmd.new_dist >= LATE_HALF) begin
            ranks = 1'b0;
        end else if (lead < LATE_HALF) begin
            ranks = cmd.new_dist < lead;
        end else if (late < LATE_WINDOW) begin
            ranks = (type_reg == cmd.special_type) && cmd.special_done;
        end else begin
            ranks = 1'b1;
        end
    end

    assign reach = reach_in || !valid || (!cmd.key_special && ranks);
    assign settle = cmd.front || (reach && !(valid && due_reg == cmd.new_due));
    assign here = settle && !point_in;

    assign found_out = found_in || hit;
    assign fdue_out = (hit && !found_in) ? due_reg : fdue_in;
    assign reach_out = reach;
    assign point_out = point_in || settle;

    always_comb begin
        type_next = type_reg;
        due_next = due_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (point_in) begin
                    type_next = prev_type;
                    due_next = prev_due;
                end else if (here) begin
                    type_next = cmd.key_type;
                    due_next = cmd.new_due;
                end
            end
            CELL_REMOVE: begin
                if (found_in || hit) begin
                    type_next = next_type;
                    due_next = next_due;
                end
            end
            CELL_SHIFT: begin
                due_next = due_reg + cmd.offset;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        due_reg <= due_next;
    end

    assign cell_type = type_reg;
    assign cell_due = due_reg;

endmodule

// ===== hdl/teq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_chain
// Row of queue cells with the search and shift links between neighbors.
// ----------------------------------------------------------------------------
module teq_chain
    import teq_pkg::*;
(
    input  logic             aclk,
    input  teq_cmd_t         cmd,
    input  logic [CNT_W-1:0] fill,
    output teq_stat_t        stat
);

    logic [3:0]  ctype [QUEUE_DEPTH];
    logic [31:0] cdue  [QUEUE_DEPTH];
    logic        found [QUEUE_DEPTH+1];
    logic [31:0] fdue  [QUEUE_DEPTH+1];
    logic        reach [QUEUE_DEPTH+1];
    logic        point [QUEUE_DEPTH+1];

    assign found[0] = cmd.from_head;
    assign fdue[0] = '0;
    assign reach[0] = 1'b0;
    assign point[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam int PI = (i == 0) ? 0 : i - 1;
        localparam int NI = (i == QUEUE_DEPTH - 1) ? i : i + 1;
        teq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .valid     (fill > CNT_W'(i)),
            .prev_type (ctype[PI]),
            .prev_due  (cdue[PI]),
            .next_type (ctype[NI]),
            .next_due  (cdue[NI]),
            .found_in  (found[i]),
            .fdue_in   (fdue[i]),
            .reach_in  (reach[i]),
            .point_in  (point[i]),
            .cell_type (ctype[i]),
            .cell_due  (cdue[i]),
            .found_out (found[i+1]),
            .fdue_out  (fdue[i+1]),
            .reach_out (reach[i+1]),
            .point_out (point[i+1])
        );
    end

    assign stat.any_match = found[QUEUE_DEPTH];
    assign stat.found_due = fdue[QUEUE_DEPTH];
    assign stat.ins_head = point[1];
    assign stat.head_type = ctype[0];
    assign stat.head_due = cdue[0];
    assign stat.second_due = cdue[1];

endmodule

// ===== hdl/timed_event_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue
// Time-ordered event queue against a wrapping count, built as a cell row.
// ----------------------------------------------------------------------------
// Each request is handled by a small sequencer driving a row of QUEUE_DEPTH
// cells that compare and shift in parallel. Add, pop, delete, find and clear
// work in ST_EXEC; rebase goes on through ST_RB_DEL_SPECIAL, ST_RB_SHIFT,
// ST_RB_ADD_COMPARE and ST_RB_ADD_SPECIAL. The result waits in ST_OUT for m_ready,
// and a new request is taken only after the previous result has been accepted.
module timed_event_queue
    import teq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  teq_req_t   s_req,
    output logic       m_valid,
    input  logic       m_ready,
    output teq_rsp_t   m_rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    teq_state_t       state_reg, state_next;
    teq_req_t         req_reg;
    logic [3:0]       special_reg, compare_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             done_reg, done_next;
    logic [31:0]      due_reg, due_next;
    logic             present_reg, present_next;
    logic [31:0]      found_reg, found_next;
    logic [1:0]       status_reg, status_next;
    teq_cmd_t         cmd;
    teq_stat_t        stat;
    logic             full, add_step;
    logic [3:0]       add_type;
    logic [31:0]      add_due;
    logic             add_front;

    teq_chain u_chain (
        .aclk (aclk),
        .cmd  (cmd),
        .fill (fill_reg),
        .stat (stat)
    );

    assign full = fill_reg >= CNT_W'(QUEUE_DEPTH);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = (req_reg.operation == OP_REBASE) ? ST_RB_DEL_SPECIAL : ST_OUT;
            end
            ST_RB_DEL_SPECIAL: state_next = ST_RB_SHIFT;
            ST_RB_SHIFT:       state_next = ST_RB_ADD_COMPARE;
            ST_RB_ADD_COMPARE: state_next = ST_RB_ADD_SPECIAL;
            ST_RB_ADD_SPECIAL: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        add_step = 1'b0;
        add_type = req_reg.event_type;
        add_front = 1'b0;
        add_due = (req_reg.operation == OP_ADD_DELAY) ?
                  req_reg.now_count + req_reg.value : req_reg.value;
        cmd.key_type = req_reg.event_type;
        case (state_reg)
            ST_EXEC: begin
                if (req_reg.operation == OP_ADD_DELAY || req_reg.operation == OP_ADD_AT) begin
                    add_step = 1'b1;
                    add_front = req_reg.to_front;
                    if (req_reg.to_front) begin
                        add_due = req_reg.now_count;
                    end
                end else if (req_reg.operation == OP_REBASE) begin
                    cmd.key_type = compare_reg;
                end
            end
            ST_RB_DEL_SPECIAL: cmd.key_type = special_reg;
            ST_RB_ADD_COMPARE: begin
                add_step = 1'b1;
                add_type = compare_reg;
                add_due = req_reg.compare_value;
            end
            ST_RB_ADD_SPECIAL: begin
                add_step = 1'b1;
                add_type = special_reg;
                add_due = '0;
            end
            default: begin
            end
        endcase
        if (add_step) begin
            cmd.key_type = add_type;
        end
        cmd.op = CELL_HOLD;
        cmd.from_head = 1'b0;
        cmd.new_due = add_due;
        cmd.new_dist = add_due - req_reg.now_count;
        cmd.front = add_front;
        cmd.key_special = (add_type == special_reg);
        cmd.special_type = special_reg;
        cmd.special_done = done_reg && (req_reg.now_count <= LATE_HALF);
        cmd.now_count = req_reg.now_count;
        cmd.offset = req_reg.value - req_reg.now_count;

        fill_next = fill_reg;
        done_next = done_reg;
        due_next = due_reg;
        present_next = present_reg;
        found_next = found_reg;
        status_next = status_reg;

        if (add_step) begin
            if (state_reg == ST_EXEC) begin
                present_next = stat.any_match;
            end
            if (full) begin
                status_next = STATUS_FULL;
            end else begin
                cmd.op = CELL_INSERT;
                fill_next = fill_reg + 1'b1;
                if (add_front) begin
                    due_next = req_reg.now_count;
                end else begin
                    done_next = cmd.special_done;
                    due_next = stat.ins_head ? add_due : stat.head_due;
                end
            end
        end else begin
            case (state_reg)
                ST_EXEC: begin
                    case (req_reg.operation)
                        OP_POP: begin
                            if (fill_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                cmd.op = CELL_REMOVE;
                                cmd.from_head = 1'b1;
                                fill_next = fill_reg - 1'b1;
                                if (stat.head_type == special_reg) begin
                                    done_next = 1'b1;
                                end
                                if (fill_reg >= CNT_W'(2) &&
                                    (stat.second_due > req_reg.now_count ||
                                     (req_reg.now_count - stat.second_due) < LATE_HALF)) begin
                                    due_next = stat.second_due;
                                end else begin
                                    due_next = '0;
                                end
                            end
                        end
                        OP_DELETE, OP_REBASE: begin
                            if (req_reg.operation == OP_DELETE) begin
                                present_next = stat.any_match;
                            end
                            if (stat.any_match) begin
                                cmd.op = CELL_REMOVE;
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_FIND: begin
                            present_next = stat.any_match;
                            found_next = stat.found_due;
                        end
                        OP_CLEAR: fill_next = '0;
                        default: begin
                        end
                    endcase
                end
                ST_RB_DEL_SPECIAL: begin
                    if (stat.any_match) begin
                        cmd.op = CELL_REMOVE;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                ST_RB_SHIFT: cmd.op = CELL_SHIFT;
                ST_IDLE: begin
                    present_next = 1'b0;
                    found_next = '0;
                    status_next = STATUS_OK;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
        cfg_ready = 1'b1;
        m_rsp.next_due = due_reg;
        m_rsp.found_count = found_reg;
        m_rsp.head_type = (fill_reg != '0) ? stat.head_type : 4'd0;
        m_rsp.is_empty = (fill_reg == '0);
        m_rsp.was_present = present_reg;
        m_rsp.status = status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            special_reg <= 4'd0;
            compare_reg <= 4'd1;
            fill_reg <= '0;
            done_reg <= 1'b1;
            due_reg <= '0;
            present_reg <= 1'b0;
            found_reg <= '0;
            status_reg <= STATUS_OK;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            done_reg <= done_next;
            due_reg <= due_next;
            present_reg <= present_next;
            found_reg <= found_next;
            status_reg <= status_next;
            if (cfg_valid && cfg_index == REG_SPECIAL_TYPE) begin
                special_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_COMPARE_TYPE) begin
                compare_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level above depth");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready && !m_valid)
        else $error("request accepted while the sequencer was busy");
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == STATUS_EMPTY) |-> (fill_reg == '0))
        else $error("empty pop reported on a non-empty queue");
    a_full_keeps_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && full && add_step) |=> (fill_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("refused add changed the fill level");
`endif

endmodule

// ===== sim/tb_timed_event_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_queue
// Self-checking testbench of the timed event queue.
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge with random gaps, results are taken
// with random stalls, and a scoreboard class predicts each response from its
// own copy of the queue and checks the responses in order.
module tb_timed_event_queue;
    import teq_pkg::*;

    class teq_scoreboard;
        logic [3:0]  special_type;
        logic [3:0]  compare_type;
        logic [3:0]  q_type [QUEUE_DEPTH];
        logic [31:0] q_due [QUEUE_DEPTH];
        int          fill;
        bit          special_done;
        logic [31:0] next_due_reg;
        teq_rsp_t    pending [$];
        int          errors;

        function new();
            special_type = 4'd0;
            compare_type = 4'd1;
            fill = 0;
            special_done = 1'b1;
            next_due_reg = '0;
            errors = 0;
        endfunction

        function int locate(logic [3:0] t);
            for (int i = 0; i < fill; i++) begin
                if (q_type[i] == t) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void remove_at(int pos);
            for (int i = pos; i + 1 < fill; i++) begin
                q_type[i] = q_type[i + 1];
                q_due[i] = q_due[i + 1];
            end
            fill--;
        endfunction

        function void insert_at(int pos, logic [3:0] t, logic [31:0] d);
            for (int i = fill; i > pos; i--) begin
                q_type[i] = q_type[i - 1];
                q_due[i] = q_due[i - 1];
            end
            q_type[pos] = t;
            q_due[pos] = d;
            fill++;
        endfunction

        function bit ranks_ahead(logic [31:0] d, int pos, logic [31:0] now);
            logic [31:0] da;
            logic [31:0] db;
            da = d - now;
            db = q_due[pos] - now;
            if (da >= LATE_HALF) begin
                return 1'b0;
            end
            if (db < LATE_HALF) begin
                return da < db;
            end
            if (now - q_due[pos] < LATE_WINDOW) begin
                return q_type[pos] == special_type && special_done;
            end
            return 1'b1;
        endfunction

        function bit schedule(logic [3:0] t, logic [31:0] d, logic [31:0] now, bit front);
            int pos;
            bit sp;
            pos = 0;
            sp = (t == special_type);
            if (fill >= QUEUE_DEPTH) begin
                return 1'b0;
            end
            if (front) begin
                insert_at(0, t, now);
                next_due_reg = now;
                return 1'b1;
            end
            if (now > LATE_HALF) begin
                special_done = 1'b0;
            end
            while (pos < fill && !(!sp && ranks_ahead(d, pos, now))) begin
                pos++;
            end
            if (pos < fill && !sp) begin
                while (pos < fill && q_due[pos] == d) begin
                    pos++;
                end
            end
            insert_at(pos, t, d);
            next_due_reg = q_due[0];
            return 1'b1;
        endfunction

        function void note_request(teq_req_t r);
            teq_rsp_t e;
            int p;
            e = '0;
            case (r.operation)
                OP_ADD_DELAY, OP_ADD_AT: begin
                    e.was_present = locate(r.event_type) >= 0;
                    if (!schedule(r.event_type, r.operation == OP_ADD_DELAY ?
                                  r.now_count + r.value : r.value, r.now_count, r.to_front)) begin
                        e.status = STATUS_FULL;
                    end
                end
                OP_POP: begin
                    if (fill == 0) begin
                        e.status = STATUS_EMPTY;
                    end else begin
                        if (q_type[0] == special_type) begin
                            special_done = 1'b1;
                        end
                        remove_at(0);
                        if (fill != 0 && (q_due[0] > r.now_count ||
                                          r.now_count - q_due[0] < LATE_HALF)) begin
                            next_due_reg = q_due[0];
                        end else begin
                            next_due_reg = '0;
                        end
                    end
                end
                OP_DELETE: begin
                    p = locate(r.event_type);
                    e.was_present = p >= 0;
                    if (p >= 0) begin
                        remove_at(p);
                    end
                end
                OP_FIND: begin
                    p = locate(r.event_type);
                    e.was_present = p >= 0;
                    if (p >= 0) begin
                        e.found_count = q_due[p];
                    end
                end
                OP_REBASE: begin
                    p = locate(compare_type);
                    if (p >= 0) begin
                        remove_at(p);
                    end
                    p = locate(special_type);
                    if (p >= 0) begin
                        remove_at(p);
                    end
                    for (int i = 0; i < fill; i++) begin
                        q_due[i] = q_due[i] - r.now_count + r.value;
                    end
                    if (!schedule(compare_type, r.compare_value, r.now_count, 1'b0)) begin
                        e.status = STATUS_FULL;
                    end
                    if (!schedule(special_type, 32'd0, r.now_count, 1'b0)) begin
                        e.status = STATUS_FULL;
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            e.next_due = next_due_reg;
            e.head_type = fill != 0 ? q_type[0] : 4'd0;
            e.is_empty = fill == 0;
            pending.push_back(e);
        endfunction

        task check_response(teq_rsp_t got);
            teq_rsp_t e;
            if (pending.size() == 0) begin
                report_error("response with nothing outstanding");
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got.next_due !== e.next_due) begin
                report_error($sformatf("next_due %h, want %h", got.next_due, e.next_due));
            end
            if (got.found_count !== e.found_count) begin
                report_error($sformatf("found_count %h, want %h", got.found_count,
                                       e.found_count));
            end
            if (got.head_type !== e.head_type) begin
                report_error($sformatf("head_type %h, want %h", got.head_type, e.head_type));
            end
            if (got.is_empty !== e.is_empty) begin
                report_error($sformatf("is_empty %b, want %b", got.is_empty, e.is_empty));
            end
            if (got.was_present !== e.was_present) begin
                report_error($sformatf("was_present %b, want %b", got.was_present,
                                       e.was_present));
            end
            if (got.status !== e.status) begin
                report_error($sformatf("status %h, want %h", got.status, e.status));
            end
        endtask

        task report_error(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    teq_req_t s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    teq_rsp_t m_rsp;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    teq_scoreboard sb = new();
    bit     quiet_phase = 1'b0;
    bit     hold_rsp = 1'b0;
    longint cycles = 0;
    logic [31:0] now_count = 32'd0;
    logic [3:0]  type_pool [4];

    timed_event_queue DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_response(m_rsp);
        end
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_rsp) begin
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4000;
        @(negedge aclk);
        hold_rsp = 1'b1;
        repeat (300) @(negedge aclk);
        hold_rsp = 1'b0;
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_SPECIAL_TYPE) begin
            sb.special_type = data;
        end else begin
            sb.compare_type = data;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(teq_req_t r);
        @(negedge aclk);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic teq_req_t make_req(logic [2:0] op, logic [3:0] t, logic [31:0] v,
                                          logic [31:0] now, logic [31:0] cv, bit front);
        teq_req_t r;
        r.operation = op;
        r.event_type = t;
        r.value = v;
        r.now_count = now;
        r.compare_value = cv;
        r.to_front = front;
        return r;
    endfunction

    task automatic random_phase(int n);
        teq_req_t r;
        int k;
        for (int i = 0; i < n; i++) begin
            now_count = now_count + $urandom_range(0, 3000);
            if ($urandom_range(0, 30) == 0) begin
                now_count = $urandom;
            end
            r.event_type = $urandom_range(0, 9) < 8 ? type_pool[$urandom_range(0, 3)]
                                                    : 4'($urandom);
            r.now_count = now_count;
            r.compare_value = $urandom_range(0, 1) ? now_count + $urandom_range(0, 5000)
                                                   : $urandom;
            r.to_front = $urandom_range(0, 12) == 0;
            k = $urandom_range(0, 99);
            if (k < 30) begin
                r.operation = OP_ADD_DELAY;
                r.value = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 4000);
            end else if (k < 45) begin
                r.operation = OP_ADD_AT;
                r.value = $urandom_range(0, 1) ? now_count - $urandom_range(0, 4000) : $urandom;
            end else if (k < 65) begin
                r.operation = OP_POP;
                r.value = $urandom;
            end else if (k < 75) begin
                r.operation = OP_DELETE;
                r.value = $urandom;
            end else if (k < 87) begin
                r.operation = OP_FIND;
                r.value = $urandom;
            end else if (k < 94) begin
                r.operation = OP_REBASE;
                r.value = $urandom_range(0, 1) ? 32'd0 : $urandom;
            end else if (k < 98) begin
                r.operation = OP_CLEAR;
                r.value = $urandom;
            end else begin
                r.operation = 3'd7;
                r.value = $urandom;
            end
            send(r);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_reg(REG_SPECIAL_TYPE, 4'd0);
        write_reg(REG_COMPARE_TYPE, 4'd1);

        send(make_req(OP_POP, 4'd3, 32'd0, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_ADD_DELAY, 4'd5, 32'd100, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_ADD_AT, 4'd6, 32'd100, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_ADD_AT, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_ADD_DELAY, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send(make_req(OP_FIND, 4'd6, 32'd0, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_FIND, 4'd9, 32'd0, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_DELETE, 4'd5, 32'd0, 32'd0, 32'd0, 1'b0));
        send(make_req(OP_ADD_AT, 4'd7, 32'h8000_0100, 32'h8000_0200, 32'd0, 1'b0));
        send(make_req(OP_ADD_AT, 4'd8, 32'h7000_0000, 32'h8000_0200, 32'd0, 1'b0));
        send(make_req(OP_POP, 4'd0, 32'd0, 32'hC000_0000, 32'd0, 1'b0));
        send(make_req(OP_REBASE, 4'd0, 32'h1234_5678, 32'h8000_0300, 32'h4000, 1'b0));
        send(make_req(OP_POP, 4'd0, 32'd0, 32'h0, 32'd0, 1'b0));
        send(make_req(3'd7, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        for (int i = 0; i < 17; i++) begin
            send(make_req(OP_ADD_DELAY, 4'(i), 32'd50, 32'd10, 32'd0, 1'b0));
        end
        send(make_req(OP_REBASE, 4'd2, 32'd0, 32'd10, 32'd0, 1'b0));
        send(make_req(OP_CLEAR, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                quiet_phase = 1'b1;
            end
            if (ph != 0) begin
                write_reg(REG_SPECIAL_TYPE, ph == 1 ? 4'd15 : 4'($urandom));
                write_reg(REG_COMPARE_TYPE, ph == 1 ? 4'd0 : ph == 2 ? 4'd15 : 4'($urandom));
            end
            type_pool[0] = sb.special_type;
            type_pool[1] = sb.compare_type;
            type_pool[2] = 4'($urandom);
            type_pool[3] = 4'($urandom);
            random_phase(180);
            drain();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
